// ===== src/rswmm_pkg.sv =====
`timescale 1ns / 1ps

package rswmm_pkg;

  localparam int MaxWindow    = 8;
  localparam int AzimuthLines = 2048;
  localparam int RangeCells   = 512;

  localparam int AzBits    = 11;
  localparam int RcBits    = 9;
  localparam int AmpBits   = 8;
  localparam int WinBits   = 4;
  localparam int TagBits   = 16;
  localparam int HistBits  = AmpBits * MaxWindow;
  localparam int EntryBits = HistBits + TagBits;

  localparam int AzAddrBits   = $clog2(AzimuthLines);
  localparam int RcAddrBits   = $clog2(RangeCells);
  localparam int CellAddrBits = AzAddrBits + RcAddrBits;
  localparam int CellCount    = AzimuthLines * RangeCells;

  localparam logic [AmpBits-1:0] FullScale = 8'd255;

  typedef enum logic [1:0] {
    CfgWindow   = 2'd0,
    CfgMinLevel = 2'd1,
    CfgMaxLevel = 2'd2
  } cfg_index_e;

  // One sample between the read issue and the read-modify-write stage.
  typedef struct packed {
    logic                    in_range;
    logic                    seen_ok;
    logic [TagBits-1:0]      snum;
    logic [AzBits-1:0]       az;
    logic [RcBits-1:0]       rc;
    logic [AmpBits-1:0]      amp;
    logic [CellAddrBits-1:0] addr;
    logic [WinBits-1:0]      win;
    logic                    fwd_hit;
    logic [EntryBits-1:0]    fwd_data;
  } rmw_stage_t;

endpackage

// ===== src/rswmm_ram.sv =====
`timescale 1ns / 1ps

module rswmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/radar_sweep_window_max_merge.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: azimuth, range_cell, amplitude;
//                                                   tuser: new_sweep
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_azimuth, out_cell,
//                                                   merged_amplitude; tuser: visible, strong_res
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while neither the clearing pass nor an m_axis stall holds the
// input. The memory read is issued in the cycle a word is accepted; the read-modify-write and
// window maximum follow in the merge stage, whose result is registered for m_axis.
// After reset a clearing pass writes one memory entry per cycle over all CellCount (1048576)
// entries, during which s_axis_tready stays low; configuration writes are taken at all times.
// A stall on m_axis holds the merge stage and then the input; the output register lets a
// new word enter while a result waits.

module radar_sweep_window_max_merge
  import rswmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // azimuth[10:0], range_cell[19:11], amplitude[27:20]
  input  logic [0:0]  s_axis_tuser,   // new_sweep[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_azimuth[10:0], out_cell[19:11],
                                      // merged_amplitude[27:20]
  output logic [1:0]  m_axis_tuser,   // visible[0], strong_res[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // Configuration registers.
  logic [WinBits-1:0] win_q;
  logic [AmpBits-1:0] min_q, max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinBits'(1);
      min_q <= '0;
      max_q <= FullScale;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgWindow:   win_q <= cfg_data_i[WinBits-1:0];
        CfgMinLevel: min_q <= cfg_data_i;
        CfgMaxLevel: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass state.
  logic                    clearing_q;
  logic [CellAddrBits-1:0] clr_addr_q;

  // Sweep counters.
  logic [TagBits-1:0] snum_q, snum_d;
  logic [WinBits-1:0] seen_q, seen_d;

  // Pipeline.
  rmw_stage_t s1_q, s1_d;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_user_q;

  logic in_accept, s1_adv, s1_emit, out_free;

  // Input fields.
  logic               in_ns;
  logic [AzBits-1:0]  in_az;
  logic [RcBits-1:0]  in_rc;
  logic [AmpBits-1:0] in_amp;
  logic [WinBits-1:0] win_eff;

  assign in_ns  = s_axis_tuser[0];
  assign in_az  = s_axis_tdata[AzBits-1:0];
  assign in_rc  = s_axis_tdata[AzBits+RcBits-1:AzBits];
  assign in_amp = s_axis_tdata[AzBits+RcBits+AmpBits-1:AzBits+RcBits];

  // A window of zero acts as one, beyond the history depth as the full depth.
  always_comb begin
    win_eff = win_q;
    if (win_q == '0) begin
      win_eff = WinBits'(1);
    end else if (win_q > WinBits'(MaxWindow)) begin
      win_eff = WinBits'(MaxWindow);
    end
  end

  // Memory ports.
  logic                    ram_we;
  logic [CellAddrBits-1:0] ram_waddr, ram_raddr;
  logic [EntryBits-1:0]    ram_wdata, ram_rdata;

  rswmm_ram #(
    .Width(EntryBits),
    .Depth(CellCount)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_emit       = s1_q.in_range && s1_q.seen_ok;
  assign s1_adv        = s1_valid_q && (!s1_emit || out_free);
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign ram_raddr = {in_az[AzAddrBits-1:0], in_rc[RcAddrBits-1:0]};

  // Stage 0: sweep counting and read issue.
  always_comb begin
    snum_d = snum_q;
    seen_d = seen_q;
    if (in_accept && in_ns) begin
      snum_d = snum_q + TagBits'(1);
      if (seen_q < WinBits'(MaxWindow)) begin
        seen_d = seen_q + WinBits'(1);
      end
    end
    s1_d.in_range = ({1'b0, in_az} < (AzBits+1)'(AzimuthLines)) &&
                    ({1'b0, in_rc} < (RcBits+1)'(RangeCells));
    s1_d.seen_ok  = seen_d >= win_eff;
    s1_d.snum     = snum_d;
    s1_d.az       = in_az;
    s1_d.rc       = in_rc;
    s1_d.amp      = in_amp;
    s1_d.addr     = ram_raddr;
    s1_d.win      = win_eff;
    // A write to the same entry in this cycle is not seen by the read.
    s1_d.fwd_hit  = ram_we && (ram_waddr == ram_raddr);
    s1_d.fwd_data = ram_wdata;
  end

  // Stage 1: age, insert, write back and take the window maximum.
  logic [EntryBits-1:0] entry;
  logic [HistBits-1:0]  hist_old, hist_new;
  logic [TagBits-1:0]   gap;
  logic [AmpBits-1:0]   merged, byte_k;
  logic                 visible, strong_hit;

  always_comb begin
    entry    = s1_q.fwd_hit ? s1_q.fwd_data : ram_rdata;
    hist_old = entry[HistBits-1:0];
    gap      = s1_q.snum - entry[EntryBits-1:HistBits];
    hist_new = '0;
    for (int k = 0; k < MaxWindow; k++) begin
      if (gap == TagBits'(k)) begin
        hist_new = hist_old << (AmpBits * k);
      end
    end
    hist_new[AmpBits-1:0] = s1_q.amp;

    merged = '0;
    for (int k = 0; k < MaxWindow; k++) begin
      byte_k = hist_new[AmpBits*k +: AmpBits];
      if ((WinBits'(k) < s1_q.win) && (byte_k > merged)) begin
        merged = byte_k;
      end
    end
    visible    = (merged != '0) && (merged >= min_q) && (merged <= max_q);
    strong_hit = merged == FullScale;
  end

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_q.in_range;
      ram_waddr = s1_q.addr;
      ram_wdata = {s1_q.snum, hist_new};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      snum_q      <= '0;
      seen_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + CellAddrBits'(1);
        if (clr_addr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      snum_q <= snum_d;
      seen_q <= seen_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_emit) begin
      out_data_q <= {4'b0, merged, s1_q.rc, s1_q.az};
      out_user_q <= {strong_hit, visible};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
